[sv/assert_macros.svh]
// Assertion macros used by the RTL of the SNR meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/snr_pkg.sv]
// Package with the fixed widths, constants and status codes of the SNR meter.
package snr_pkg;

    // Width of the shared multiplier operands.
    localparam int MUL_W = 32;
    // Fixed result field widths.
    localparam int OUT_W  = 48;
    localparam int SNR_W  = 16;
    localparam int STAT_W = 3;
    // Fraction bits of the log2 result.
    localparam int LOG_FRAC = 16;

    // 10*log10(2) in Q.24.
    localparam logic [MUL_W-1:0] TEN_LOG10_2_Q24 = 32'd50504453;

    // Saturation values of the dB result.
    localparam logic [SNR_W-1:0] SNR_MAX = 16'h7FFF;
    localparam logic [SNR_W-1:0] SNR_MIN = 16'h8000;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_ZERO_ERR  = 3'd1,
        STAT_ZERO_REF  = 3'd2,
        STAT_SILENT    = 3'd3,
        STAT_COUNT_SAT = 3'd4
    } t_status;

endpackage

[sv/snr_error_meter.sv]
// SNR meter: accumulates sample pairs and computes power, error and SNR in dB.
// A pair that is not last takes an accept step plus five multiply/accumulate steps.
// A last pair adds the result sequence: a restoring divider for each quotient (3 in plain
// mode, 6 in normalize mode) and two log2 evaluations, unless a zero or silent check ends
// it early; all products use one shared 32x32 multiplier.
// Synchronous active-low reset clears all accumulators, the mode and the output valid.
`include "assert_macros.svh"

module snr_error_meter
    import snr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_normalize_mode,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ref,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_test,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [COUNT_BITS-1:0]         o_sample_count,
    output logic [OUT_W-1:0]              o_power_ref,
    output logic [OUT_W-1:0]              o_power_test,
    output logic [OUT_W-1:0]              o_mean_error,
    output logic signed [SNR_W-1:0]       o_snr_db,
    output logic [STAT_W-1:0]             o_status
);

    localparam int S          = SAMPLE_BITS;
    localparam int C          = COUNT_BITS;
    localparam int SQ_SUM_W   = 2 * S - 1 + C;
    localparam int DIFF_SUM_W = 2 * S + C;
    localparam int CROSS_W    = 2 * S + C;
    localparam int PK2_W      = 2 * S;
    localparam int E_W        = C + 34;
    localparam int DEN_W      = (2 * S > C) ? 2 * S : C;
    localparam int DIVN_W     = 2 * S + C + 32;
    localparam int DCNT_W     = $clog2(DIVN_W);
    localparam int LOG_W      = (2 * S + C > C + 34) ? 2 * S + C : C + 34;
    localparam int LP_W       = $clog2(LOG_W);
    localparam int LQ_W       = LP_W + LOG_FRAC;
    localparam int PROD_W     = 2 * MUL_W;
    localparam logic [C-1:0] COUNT_FULL = '1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ACC, ST_DISP, ST_DIV, ST_LNRM, ST_LMUL, ST_LUPD, ST_DBR
    } t_state;

    typedef enum logic [4:0] {
        SP_N_PR, SP_N_PT, SP_N_ME, SP_N_CHK, SP_N_LA, SP_N_LB,
        SP_Z_SIL, SP_Z_MA2, SP_Z_MB2, SP_Z_MAB, SP_Z_T1, SP_Z_T2, SP_Z_T3,
        SP_Z_ESUM, SP_Z_ESGN, SP_Z_PR, SP_Z_PT, SP_Z_ME, SP_Z_CHK,
        SP_Z_LA, SP_Z_LB, SP_DB, SP_EMIT
    } t_step;

    // Order of the result sequence.
    function automatic t_step step_after(input t_step s);
        unique case (s)
            SP_N_PR:   return SP_N_PT;
            SP_N_PT:   return SP_N_ME;
            SP_N_ME:   return SP_N_CHK;
            SP_N_LA:   return SP_N_LB;
            SP_N_LB:   return SP_DB;
            SP_Z_MA2:  return SP_Z_MB2;
            SP_Z_MB2:  return SP_Z_MAB;
            SP_Z_MAB:  return SP_Z_T1;
            SP_Z_T1:   return SP_Z_T2;
            SP_Z_T2:   return SP_Z_T3;
            SP_Z_T3:   return SP_Z_ESUM;
            SP_Z_ESUM: return SP_Z_ESGN;
            SP_Z_ESGN: return SP_Z_PR;
            SP_Z_PR:   return SP_Z_PT;
            SP_Z_PT:   return SP_Z_ME;
            SP_Z_ME:   return SP_Z_CHK;
            SP_Z_LA:   return SP_Z_LB;
            SP_Z_LB:   return SP_DB;
            default:   return SP_EMIT;
        endcase
    endfunction

    t_state  r_state;
    t_step   r_step;
    logic    r_nrm;

    // Latched input pair.
    logic signed [S-1:0] r_a, r_b;
    logic                r_last;
    logic [2:0]          r_acnt;

    // Accumulators.
    logic [C-1:0]          r_count;
    logic [SQ_SUM_W-1:0]   r_saa, r_sbb;
    logic [CROSS_W-1:0]    r_sab;
    logic [DIFF_SUM_W-1:0] r_sdd;
    logic [S-1:0]          r_pka, r_pkb;

    // Working registers of the result sequence.
    logic [PROD_W-1:0] r_prod;
    logic [PK2_W-1:0]  r_ma2, r_mb2, r_mab;
    logic [E_W-1:0]    r_t1, r_t2, r_t3, r_e;
    logic [OUT_W-1:0]  r_pr, r_pt, r_me;
    logic [SNR_W-1:0]  r_snr;
    t_status           r_st;
    logic [LQ_W-1:0]   r_la, r_lb;

    // Divider registers.
    logic [DIVN_W-1:0] r_dq;
    logic [DEN_W-1:0]  r_dr, r_dd;
    logic [DCNT_W-1:0] r_dcnt;

    // log2 unit registers.
    logic [LOG_W-1:0]    r_lx;
    logic [LP_W-1:0]     r_lp;
    logic [MUL_W-1:0]    r_lm;
    logic [LOG_FRAC-1:0] r_lf;
    logic [3:0]          r_lcnt;

    // Output register.
    logic             r_out_valid;
    logic [C-1:0]     r_out_count;
    logic [OUT_W-1:0] r_out_pr, r_out_pt, r_out_me;
    logic [SNR_W-1:0] r_out_snr;
    t_status          r_out_status;

    // Sample magnitudes and difference magnitude.
    logic signed [S:0] a_ext, b_ext, ab_diff;
    logic [S-1:0]      mag_a, mag_b, mag_d;
    always_comb begin
        a_ext   = {r_a[S-1], r_a};
        b_ext   = {r_b[S-1], r_b};
        ab_diff = a_ext - b_ext;
        mag_a   = a_ext[S] ? S'(-a_ext) : a_ext[S-1:0];
        mag_b   = b_ext[S] ? S'(-b_ext) : b_ext[S-1:0];
        mag_d   = ab_diff[S] ? S'(-ab_diff) : ab_diff[S-1:0];
    end

    // Cross sum sign and magnitude.
    logic               sab_neg;
    logic [CROSS_W-1:0] cmag;
    assign sab_neg = r_sab[CROSS_W-1];
    assign cmag    = sab_neg ? (~r_sab + 1'b1) : r_sab;

    // dB difference of the two log2 values.
    logic signed [LQ_W:0] db_d;
    logic                 db_neg;
    logic [LQ_W-1:0]      db_mag;
    logic [PROD_W-1:0]    db_sum;
    logic [MUL_W-1:0]     db_r;
    logic [SNR_W-1:0]     db_snr;
    always_comb begin
        db_d   = $signed({1'b0, r_la}) - $signed({1'b0, r_lb});
        db_neg = db_d[LQ_W];
        db_mag = db_neg ? LQ_W'(-db_d) : db_d[LQ_W-1:0];
        db_sum = r_prod + (PROD_W'(1) << 31);
        db_r   = db_sum[PROD_W-1:MUL_W];
        if (db_neg) begin
            db_snr = (db_r > MUL_W'(32768)) ? SNR_MIN : SNR_W'(MUL_W'(0) - db_r);
        end else begin
            db_snr = (db_r > MUL_W'(32767)) ? SNR_MAX : db_r[SNR_W-1:0];
        end
    end

    // Shared multiplier operand selection.
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_ACC: begin
                case (r_acnt)
                    3'd0: begin mul_a = MUL_W'(mag_a); mul_b = MUL_W'(mag_a); end
                    3'd1: begin mul_a = MUL_W'(mag_b); mul_b = MUL_W'(mag_b); end
                    3'd2: begin mul_a = MUL_W'(mag_a); mul_b = MUL_W'(mag_b); end
                    3'd3: begin mul_a = MUL_W'(mag_d); mul_b = MUL_W'(mag_d); end
                    default: ;
                endcase
            end
            ST_DISP: begin
                case (r_step)
                    SP_Z_MA2: begin mul_a = MUL_W'(r_pka); mul_b = MUL_W'(r_pka); end
                    SP_Z_MB2: begin mul_a = MUL_W'(r_pkb); mul_b = MUL_W'(r_pkb); end
                    SP_Z_MAB: begin mul_a = MUL_W'(r_pka); mul_b = MUL_W'(r_pkb); end
                    SP_DB:    begin mul_a = MUL_W'(db_mag); mul_b = TEN_LOG10_2_Q24; end
                    default: ;
                endcase
            end
            ST_LMUL: begin
                mul_a = r_lm;
                mul_b = r_lm;
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Divider operands for each division step.
    logic [DIVN_W-1:0] div_num;
    logic [DEN_W-1:0]  div_den;
    always_comb begin
        div_num = '0;
        div_den = DEN_W'(r_count);
        unique case (r_step)
            SP_N_PR: div_num = DIVN_W'(r_saa) << 16;
            SP_N_PT: div_num = DIVN_W'(r_sbb) << 16;
            SP_N_ME: div_num = DIVN_W'(r_sdd) << 16;
            SP_Z_T1: begin
                div_num = DIVN_W'(r_saa) << 32;
                div_den = DEN_W'(r_ma2);
            end
            SP_Z_T2: begin
                div_num = DIVN_W'(r_sbb) << 32;
                div_den = DEN_W'(r_mb2);
            end
            SP_Z_T3: begin
                div_num = DIVN_W'(cmag) << 33;
                div_den = DEN_W'(r_mab);
            end
            SP_Z_PR: div_num = DIVN_W'(r_t1 >> 16);
            SP_Z_PT: div_num = DIVN_W'(r_t2 >> 16);
            SP_Z_ME: div_num = DIVN_W'(r_e);
            default: ;
        endcase
    end

    // One restoring division step per cycle.
    logic [DEN_W:0]    div_rr, div_sub;
    logic              div_ge;
    logic [DEN_W-1:0]  n_dr;
    logic [DIVN_W-1:0] n_dq, div_q, div_q16;
    logic [OUT_W-1:0]  div_sat, div_sat16;
    always_comb begin
        div_rr    = {r_dr, r_dq[DIVN_W-1]};
        div_ge    = (div_rr >= {1'b0, r_dd});
        div_sub   = div_rr - {1'b0, r_dd};
        n_dr      = div_ge ? div_sub[DEN_W-1:0] : div_rr[DEN_W-1:0];
        n_dq      = {r_dq[DIVN_W-2:0], div_ge};
        div_q     = (r_dd == '0) ? '0 : n_dq;
        div_q16   = div_q >> 16;
        div_sat   = (|div_q[DIVN_W-1:OUT_W]) ? '1 : div_q[OUT_W-1:0];
        div_sat16 = (|div_q16[DIVN_W-1:OUT_W]) ? '1 : div_q16[OUT_W-1:0];
    end

    // Operand of each log2 step.
    logic [LOG_W-1:0] log_x;
    always_comb begin
        unique case (r_step)
            SP_N_LA: log_x = LOG_W'(r_saa);
            SP_N_LB: log_x = LOG_W'(r_sdd);
            SP_Z_LA: log_x = LOG_W'(r_t1);
            SP_Z_LB: log_x = LOG_W'(r_e);
            default: log_x = '0;
        endcase
    end

    // Mantissa squaring step of log2.
    logic [MUL_W:0]      log_sq;
    logic [MUL_W-1:0]    n_lm;
    logic [LOG_FRAC-1:0] n_lf;
    always_comb begin
        log_sq = r_prod[PROD_W-1:MUL_W-1];
        n_lm   = log_sq[MUL_W] ? log_sq[MUL_W:1] : log_sq[MUL_W-1:0];
        n_lf   = {r_lf[LOG_FRAC-2:0], log_sq[MUL_W]};
    end

    logic in_acc, out_take, out_free, emit_now;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_now = (r_state == ST_DISP) && (r_step == SP_EMIT) && out_free;

    // Sequencer, accumulators, shared units and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SP_EMIT;
            r_nrm       <= 1'b0;
            r_acnt      <= '0;
            r_count     <= '0;
            r_saa       <= '0;
            r_sbb       <= '0;
            r_sab       <= '0;
            r_sdd       <= '0;
            r_pka       <= '0;
            r_pkb       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_nrm <= i_cfg_normalize_mode;
            end
            if (out_take && !emit_now) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_a    <= i_sample_ref;
                        r_b    <= i_sample_test;
                        r_last <= i_last_sample;
                        r_acnt <= '0;
                        if (r_count != COUNT_FULL) begin
                            r_state <= ST_ACC;
                        end else if (i_last_sample) begin
                            r_st    <= STAT_OK;
                            r_step  <= r_nrm ? SP_Z_SIL : SP_N_PR;
                            r_state <= ST_DISP;
                        end
                    end
                end

                // Products in one cycle, accumulation in the next.
                ST_ACC: begin
                    r_acnt <= r_acnt + 3'd1;
                    r_prod <= mul_p;
                    case (r_acnt)
                        3'd0: begin
                            r_count <= r_count + 1'b1;
                            if (mag_a > r_pka) r_pka <= mag_a;
                            if (mag_b > r_pkb) r_pkb <= mag_b;
                        end
                        3'd1: r_saa <= r_saa + SQ_SUM_W'(r_prod[PK2_W-1:0]);
                        3'd2: r_sbb <= r_sbb + SQ_SUM_W'(r_prod[PK2_W-1:0]);
                        3'd3: begin
                            if (r_a[S-1] ^ r_b[S-1]) begin
                                r_sab <= r_sab - CROSS_W'(r_prod[PK2_W-1:0]);
                            end else begin
                                r_sab <= r_sab + CROSS_W'(r_prod[PK2_W-1:0]);
                            end
                        end
                        default: begin
                            r_sdd <= r_sdd + DIFF_SUM_W'(r_prod[PK2_W-1:0]);
                            if (r_last) begin
                                r_st    <= STAT_OK;
                                r_step  <= r_nrm ? SP_Z_SIL : SP_N_PR;
                                r_state <= ST_DISP;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    endcase
                end

                // Launches the unit of the current step, does a short step inline or emits the result.
                ST_DISP: begin
                    unique case (r_step)
                        SP_N_PR, SP_N_PT, SP_N_ME, SP_Z_T1, SP_Z_T2, SP_Z_T3,
                        SP_Z_PR, SP_Z_PT, SP_Z_ME: begin
                            r_dq    <= div_num;
                            r_dd    <= div_den;
                            r_dr    <= '0;
                            r_dcnt  <= '0;
                            r_state <= ST_DIV;
                        end
                        SP_N_LA, SP_N_LB, SP_Z_LA, SP_Z_LB: begin
                            r_lx    <= log_x;
                            r_lp    <= LP_W'(LOG_W - 1);
                            r_state <= ST_LNRM;
                        end
                        SP_N_CHK: begin
                            if (r_sdd == '0) begin
                                r_st   <= STAT_ZERO_ERR;
                                r_snr  <= SNR_MAX;
                                r_step <= SP_EMIT;
                            end else if (r_saa == '0) begin
                                r_st   <= STAT_ZERO_REF;
                                r_snr  <= SNR_MIN;
                                r_step <= SP_EMIT;
                            end else begin
                                r_step <= SP_N_LA;
                            end
                        end
                        SP_Z_SIL: begin
                            if (r_pka == '0 || r_pkb == '0) begin
                                r_st   <= STAT_SILENT;
                                r_pr   <= '0;
                                r_pt   <= '0;
                                r_me   <= '0;
                                r_snr  <= '0;
                                r_step <= SP_EMIT;
                            end else begin
                                r_step <= SP_Z_MA2;
                            end
                        end
                        SP_Z_MA2: begin
                            r_ma2  <= mul_p[PK2_W-1:0];
                            r_step <= step_after(r_step);
                        end
                        SP_Z_MB2: begin
                            r_mb2  <= mul_p[PK2_W-1:0];
                            r_step <= step_after(r_step);
                        end
                        SP_Z_MAB: begin
                            r_mab  <= mul_p[PK2_W-1:0];
                            r_step <= step_after(r_step);
                        end
                        SP_Z_ESUM: begin
                            r_e    <= r_t1 + r_t2;
                            r_step <= step_after(r_step);
                        end
                        SP_Z_ESGN: begin
                            if (sab_neg) begin
                                r_e <= r_e + r_t3;
                            end else begin
                                r_e <= (r_e > r_t3) ? (r_e - r_t3) : '0;
                            end
                            r_step <= step_after(r_step);
                        end
                        SP_Z_CHK: begin
                            if (r_e == '0) begin
                                r_st   <= STAT_ZERO_ERR;
                                r_snr  <= SNR_MAX;
                                r_step <= SP_EMIT;
                            end else if (r_t1 == '0) begin
                                r_st   <= STAT_ZERO_REF;
                                r_snr  <= SNR_MIN;
                                r_step <= SP_EMIT;
                            end else begin
                                r_step <= SP_Z_LA;
                            end
                        end
                        SP_DB: begin
                            r_prod  <= mul_p;
                            r_state <= ST_DBR;
                        end
                        default: begin
                            // Result transaction: load the output and clear the stream.
                            if (out_free) begin
                                r_out_valid  <= 1'b1;
                                r_out_count  <= r_count;
                                r_out_pr     <= r_pr;
                                r_out_pt     <= r_pt;
                                r_out_me     <= r_me;
                                r_out_snr    <= r_snr;
                                r_out_status <= (r_st == STAT_OK && r_count == COUNT_FULL) ?
                                                STAT_COUNT_SAT : r_st;
                                r_count      <= '0;
                                r_saa        <= '0;
                                r_sbb        <= '0;
                                r_sab        <= '0;
                                r_sdd        <= '0;
                                r_pka        <= '0;
                                r_pkb        <= '0;
                                r_state      <= ST_IDLE;
                            end
                        end
                    endcase
                end

                // One quotient bit per cycle.
                ST_DIV: begin
                    r_dq   <= n_dq;
                    r_dr   <= n_dr;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(DIVN_W - 1)) begin
                        case (r_step)
                            SP_N_PR, SP_Z_PR: r_pr <= div_sat;
                            SP_N_PT, SP_Z_PT: r_pt <= div_sat;
                            SP_N_ME:          r_me <= div_sat;
                            SP_Z_ME:          r_me <= div_sat16;
                            SP_Z_T1:          r_t1 <= div_q[E_W-1:0];
                            SP_Z_T2:          r_t2 <= div_q[E_W-1:0];
                            SP_Z_T3:          r_t3 <= div_q[E_W-1:0];
                            default: ;
                        endcase
                        r_step  <= step_after(r_step);
                        r_state <= ST_DISP;
                    end
                end

                // Leading-one search, one bit position per cycle.
                ST_LNRM: begin
                    if (r_lx[LOG_W-1] || r_lp == '0) begin
                        r_lm    <= r_lx[LOG_W-1 -: MUL_W];
                        r_lf    <= '0;
                        r_lcnt  <= '0;
                        r_state <= ST_LMUL;
                    end else begin
                        r_lx <= r_lx << 1;
                        r_lp <= r_lp - 1'b1;
                    end
                end

                ST_LMUL: begin
                    r_prod  <= mul_p;
                    r_state <= ST_LUPD;
                end

                // One fraction bit per squaring.
                ST_LUPD: begin
                    r_lm   <= n_lm;
                    r_lf   <= n_lf;
                    r_lcnt <= r_lcnt + 4'd1;
                    if (r_lcnt == 4'd15) begin
                        if (r_step == SP_N_LA || r_step == SP_Z_LA) begin
                            r_la <= {r_lp, n_lf};
                        end else begin
                            r_lb <= {r_lp, n_lf};
                        end
                        r_step  <= step_after(r_step);
                        r_state <= ST_DISP;
                    end else begin
                        r_state <= ST_LMUL;
                    end
                end

                // Round the scaled log difference to Q8.8 and saturate.
                ST_DBR: begin
                    r_snr   <= db_snr;
                    r_step  <= SP_EMIT;
                    r_state <= ST_DISP;
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample_count = r_out_count;
    assign o_power_ref    = r_out_pr;
    assign o_power_test   = r_out_pt;
    assign o_mean_error   = r_out_me;
    assign o_snr_db       = r_out_snr;
    assign o_status       = r_out_status;

    `ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, r_state == ST_DISP && r_step == SP_EMIT && out_free, r_out_valid && r_state == ST_IDLE && r_count == '0, "result transaction did not clear the stream")
    `ASSERT_IMPLIES(a_log_mant_norm, i_clk, i_rst_n, r_state == ST_LMUL, r_lm[MUL_W-1], "log2 mantissa not normalized")
    `ASSERT_IMPLIES(a_zero_err_sat, i_clk, i_rst_n, r_out_valid && r_out_status == STAT_ZERO_ERR, r_out_snr == SNR_MAX, "zero error without saturated SNR")
    `ASSERT_IMPLIES(a_silent_zero, i_clk, i_rst_n, r_out_valid && r_out_status == STAT_SILENT, r_out_snr == '0 && r_out_pr == '0 && r_out_me == '0, "silent channel with nonzero values")

endmodule
